// ===== hw/rtl/led_strip_segment_painter_top_macros.svh =====
// Assertion helpers for the LED strip segment painter.
`ifndef LED_STRIP_SEGMENT_PAINTER_TOP_MACROS_SVH
`define LED_STRIP_SEGMENT_PAINTER_TOP_MACROS_SVH

// Clocked check, off while reset is asserted.
`define LSSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define LSSP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/lssp_pkg.sv =====
`default_nettype none

package lssp_pkg;

    localparam int NUM_LEDS_DEF     = 32;
    localparam int NUM_SEGMENTS_DEF = 4;

    localparam int COLOUR_W = 24;

    localparam logic [23:0] COLOUR_LINEN    = 24'hFAF0E6;
    localparam logic [23:0] COLOUR_SEASHELL = 24'hFFF5EE;
    localparam logic [23:0] COLOUR_BLACK    = 24'h000000;

    // channel sum at or below this paints by power mode
    localparam int DIM_SUM_LIMIT = 3;

    typedef enum logic [1:0] {
        PWR_ON   = 2'd0,
        PWR_OFF  = 2'd1,
        PWR_HALF = 2'd2,
        PWR_NONE = 2'd3
    } power_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_SEG   = 2'd1,
        STAT_NO_ACTION = 2'd2
    } status_t;

    // overwrite each channel whose value is non-negative
    function automatic logic [23:0] apply_channels(
        input logic [23:0]       colour,
        input logic signed [8:0] r,
        input logic signed [8:0] g,
        input logic signed [8:0] b
    );
        logic [23:0] c;
        c = colour;
        if (!r[8]) c[23:16] = r[7:0];
        if (!g[8]) c[15:8]  = g[7:0];
        if (!b[8]) c[7:0]   = b[7:0];
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/led_strip_segment_painter_top.sv =====
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  segment, red, green, blue, power
//  m_       out        m_valid / m_ready  write_valid, led_index, rgb, status, last
//
//  One request at a time; s_ready is high only when idle.
//  Status-only requests go from accept straight to one result.
//  Painting: each LED takes a RAM read, a modify/write and a result, in that
//  order, as a read-modify-write through the frame buffer RAM port. While
//  m_ready is low the result is held and the next LED waits.
//  Reset: synchronous, active low; per-LED valid bits make the frame buffer
//  read as black right after reset, with no clearing pass.
`default_nettype none

`include "led_strip_segment_painter_top_macros.svh"

module led_strip_segment_painter_top #(
    parameter int NUM_LEDS     = lssp_pkg::NUM_LEDS_DEF,
    parameter int NUM_SEGMENTS = lssp_pkg::NUM_SEGMENTS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output      logic              s_ready,
    input  wire logic [3:0]        s_segment,
    input  wire logic signed [8:0] s_red,
    input  wire logic signed [8:0] s_green,
    input  wire logic signed [8:0] s_blue,
    input  wire logic [1:0]        s_power,

    output      logic              m_valid,
    input  wire logic              m_ready,
    output      logic              m_write_valid,
    output      logic [5:0]        m_led_index,
    output      logic [7:0]        m_out_red,
    output      logic [7:0]        m_out_green,
    output      logic [7:0]        m_out_blue,
    output      logic [1:0]        m_status,
    output      logic              m_last
);

    localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int SEG_W = $clog2(NUM_SEGMENTS + 1);
    localparam int SPAN  = NUM_LEDS / NUM_SEGMENTS;
    localparam int CW    = lssp_pkg::COLOUR_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_PAINT = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [SEG_W-1:0]      seg_reg;
    logic signed [8:0]     r_reg, g_reg, b_reg;
    lssp_pkg::power_t      power_reg;
    logic                  sum_le_reg;
    logic [IDX_W-1:0]      idx_reg, end_reg;
    logic                  odd_reg;
    logic [CW-1:0]         saved_reg [NUM_SEGMENTS+1];
    logic [NUM_LEDS-1:0]   fb_valid_reg;
    logic                  rd_valid_reg;

    logic                  m_valid_reg, wv_reg, last_reg;
    logic [5:0]            lidx_reg;
    logic [CW-1:0]         col_reg;
    lssp_pkg::status_t     stat_reg;

    logic                  accept;
    logic                  out_take;
    logic                  bad_seg;
    logic [SEG_W-1:0]      seg_in;
    logic signed [10:0]    chan_sum;
    logic                  sum_le;
    logic [IDX_W-1:0]      base_in;
    logic [IDX_W-1:0]      end_in;
    logic [CW-1:0]         fb_rdata;
    logic [CW-1:0]         fb_cur;
    logic [CW-1:0]         paint;

    // no request is taken while reset is asserted
    assign s_ready  = aresetn && (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_take = m_valid_reg && m_ready;

    assign bad_seg  = int'(s_segment) > NUM_SEGMENTS;
    assign seg_in   = s_segment[SEG_W-1:0];
    assign chan_sum = 11'(s_red) + 11'(s_green) + 11'(s_blue);
    assign sum_le   = chan_sum <= $signed(11'(lssp_pkg::DIM_SUM_LIMIT));

    always_comb begin
        if (seg_in == '0) begin
            base_in = '0;
            end_in  = IDX_W'(NUM_LEDS - 1);
        end else begin
            base_in = IDX_W'((int'(seg_in) - 1) * SPAN);
            end_in  = IDX_W'(int'(seg_in) * SPAN - 1);
        end
    end

    lssp_ram #(
        .WIDTH(CW),
        .DEPTH(NUM_LEDS)
    ) u_fb (
        .aclk (aclk),
        .we   (state_reg == ST_PAINT),
        .waddr(idx_reg),
        .wdata(paint),
        .re   (state_reg == ST_READ),
        .raddr(idx_reg),
        .rdata(fb_rdata)
    );

    // entries never written since reset read as black
    assign fb_cur = rd_valid_reg ? fb_rdata : lssp_pkg::COLOUR_BLACK;

    always_comb begin
        if (sum_le_reg) begin
            case (power_reg)
                lssp_pkg::PWR_ON:   paint = saved_reg[seg_reg];
                lssp_pkg::PWR_HALF: paint = odd_reg ? saved_reg[seg_reg]
                                                    : lssp_pkg::COLOUR_BLACK;
                default:            paint = lssp_pkg::COLOUR_BLACK;
            endcase
        end else begin
            paint = lssp_pkg::apply_channels(fb_cur, r_reg, g_reg, b_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (bad_seg || (sum_le && s_power == lssp_pkg::PWR_NONE) ||
                        (SPAN == 0 && seg_in != '0)) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:  state_next = ST_PAINT;
            ST_PAINT: state_next = ST_OUT;
            ST_OUT: begin
                if (out_take) begin
                    state_next = last_reg ? ST_IDLE : ST_READ;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            fb_valid_reg <= '0;
            saved_reg[0] <= lssp_pkg::COLOUR_LINEN;
            for (int k = 1; k <= NUM_SEGMENTS; k++) begin
                saved_reg[k] <= lssp_pkg::COLOUR_SEASHELL;
            end
        end else begin
            state_reg <= state_next;
            if (accept && !bad_seg) begin
                saved_reg[seg_in] <= lssp_pkg::apply_channels(saved_reg[seg_in],
                                                               s_red, s_green, s_blue);
            end
            if (state_reg == ST_PAINT) begin
                fb_valid_reg[idx_reg] <= 1'b1;
            end
            if (state_next == ST_OUT && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (out_take) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request context and result payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            rd_valid_reg <= fb_valid_reg[idx_reg];
        end
        if (accept) begin
            seg_reg    <= seg_in;
            r_reg      <= s_red;
            g_reg      <= s_green;
            b_reg      <= s_blue;
            power_reg  <= lssp_pkg::power_t'(s_power);
            sum_le_reg <= sum_le;
            idx_reg    <= base_in;
            end_reg    <= end_in;
            odd_reg    <= 1'b0;
            wv_reg     <= 1'b0;
            lidx_reg   <= '0;
            col_reg    <= '0;
            last_reg   <= 1'b1;
            if (bad_seg) begin
                stat_reg <= lssp_pkg::STAT_BAD_SEG;
            end else if (sum_le && s_power == lssp_pkg::PWR_NONE) begin
                stat_reg <= lssp_pkg::STAT_NO_ACTION;
            end else begin
                stat_reg <= lssp_pkg::STAT_OK;
            end
        end
        if (state_reg == ST_PAINT) begin
            wv_reg   <= 1'b1;
            lidx_reg <= 6'(idx_reg);
            col_reg  <= paint;
            stat_reg <= lssp_pkg::STAT_OK;
            last_reg <= (idx_reg == end_reg);
        end
        if (state_reg == ST_OUT && out_take && !last_reg) begin
            idx_reg <= idx_reg + 1'b1;
            odd_reg <= !odd_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_write_valid = wv_reg;
    assign m_led_index   = lidx_reg;
    assign m_out_red     = col_reg[23:16];
    assign m_out_green   = col_reg[15:8];
    assign m_out_blue    = col_reg[7:0];
    assign m_status      = stat_reg;
    assign m_last        = last_reg;

    `LSSP_ASSERT(a_idle_no_result, s_ready |-> !m_valid, "result pending while idle")
    `LSSP_ASSERT(a_last_to_idle, (m_valid && m_ready && m_last) |=> s_ready,
        "not idle after final result")
    `LSSP_ASSERT(a_write_ok, (m_valid && m_write_valid) |-> (m_status == lssp_pkg::STAT_OK),
        "LED write with error status")
    `LSSP_ASSERT(a_status_last, (m_valid && !m_write_valid) |-> m_last,
        "status-only result not marked last")
    `LSSP_ASSERT(a_index_range, (m_valid && m_write_valid) |-> (int'(m_led_index) < NUM_LEDS),
        "LED index beyond strip")

endmodule

`default_nettype wire

// ===== hw/rtl/lssp_ram.sv =====
`default_nettype none

module lssp_ram #(
    parameter  int WIDTH  = 24,
    parameter  int DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    aclk,
    input  wire logic                    we,
    input  wire logic [ADDR_W-1:0]       waddr,
    input  wire logic [WIDTH-1:0]        wdata,
    input  wire logic                    re,
    input  wire logic [ADDR_W-1:0]       raddr,
    output      logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sim/led_strip_segment_painter_top_tb.sv =====
`timescale 1ns / 1ps

module led_strip_segment_painter_top_tb;

    localparam int NUM_LEDS     = lssp_pkg::NUM_LEDS_DEF;
    localparam int NUM_SEGMENTS = lssp_pkg::NUM_SEGMENTS_DEF;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT    = 5000;
    localparam int TAIL_CYCLES    = 3 * NUM_LEDS + 30;

    typedef struct {
        logic [3:0]        segment;
        logic signed [8:0] red;
        logic signed [8:0] green;
        logic signed [8:0] blue;
        logic [1:0]        power;
    } paint_req_t;

    typedef struct {
        logic              write_valid;
        logic [5:0]        led_index;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        lssp_pkg::status_t status;
        logic              last;
    } led_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [3:0]        s_segment = '0;
    logic signed [8:0] s_red = '0;
    logic signed [8:0] s_green = '0;
    logic signed [8:0] s_blue = '0;
    logic [1:0]        s_power = '0;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_write_valid;
    logic [5:0] m_led_index;
    logic [7:0] m_out_red;
    logic [7:0] m_out_green;
    logic [7:0] m_out_blue;
    logic [1:0] m_status;
    logic       m_last;

    led_strip_segment_painter_top #(
        .NUM_LEDS     (NUM_LEDS),
        .NUM_SEGMENTS (NUM_SEGMENTS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_segment     (s_segment),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_power       (s_power),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_write_valid (m_write_valid),
        .m_led_index   (m_led_index),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_status      (m_status),
        .m_last        (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [23:0] strip_model [NUM_LEDS];
    logic [23:0] saved_model [NUM_SEGMENTS + 1];

    paint_req_t  pending_q[$];
    led_result_t expected_leds_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    int fail_count = 0;
    int requests_seen = 0;
    int bad_seg_seen = 0;
    int no_action_seen = 0;
    int led_writes_seen = 0;

    function automatic logic [23:0] merge_rgb(input logic [23:0] colour,
                                              input logic signed [8:0] r,
                                              input logic signed [8:0] g,
                                              input logic signed [8:0] b);
        logic [23:0] c;
        c = colour;
        if (r >= 0) c[23:16] = r[7:0];
        if (g >= 0) c[15:8]  = g[7:0];
        if (b >= 0) c[7:0]   = b[7:0];
        return c;
    endfunction

    task automatic paint_predict(input logic [3:0] seg, input logic signed [8:0] r,
                                 input logic signed [8:0] g, input logic signed [8:0] b,
                                 input logic [1:0] pwr);
        int          sum;
        int          span;
        int          base;
        int          count;
        logic [23:0] colour;
        led_result_t res;
        sum = int'(r) + int'(g) + int'(b);
        requests_seen++;
        if (int'(seg) > NUM_SEGMENTS) begin
            res = '{1'b0, 6'd0, 8'd0, 8'd0, 8'd0, lssp_pkg::STAT_BAD_SEG, 1'b1};
            expected_leds_q.push_back(res);
            bad_seg_seen++;
            return;
        end
        saved_model[seg] = merge_rgb(saved_model[seg], r, g, b);
        span = (seg == 0) ? NUM_LEDS : NUM_LEDS / NUM_SEGMENTS;
        base = (seg == 0) ? 0 : (int'(seg) - 1) * span;
        if (sum <= lssp_pkg::DIM_SUM_LIMIT && pwr == lssp_pkg::PWR_NONE) begin
            res = '{1'b0, 6'd0, 8'd0, 8'd0, 8'd0, lssp_pkg::STAT_NO_ACTION, 1'b1};
            expected_leds_q.push_back(res);
            no_action_seen++;
            return;
        end
        count = span;
        if (base + count > NUM_LEDS) count = NUM_LEDS - base;
        if (count < 0) count = 0;
        for (int i = 0; i < count; i++) begin
            if (sum <= lssp_pkg::DIM_SUM_LIMIT) begin
                if (pwr == lssp_pkg::PWR_ON)
                    colour = saved_model[seg];
                else if (pwr == lssp_pkg::PWR_OFF)
                    colour = lssp_pkg::COLOUR_BLACK;
                else
                    colour = (i % 2 == 1) ? saved_model[seg] : lssp_pkg::COLOUR_BLACK;
            end else begin
                colour = merge_rgb(strip_model[base + i], r, g, b);
            end
            strip_model[base + i] = colour;
            res = '{1'b1, 6'(base + i), colour[23:16], colour[15:8], colour[7:0],
                    lssp_pkg::STAT_OK, (i == count - 1)};
            expected_leds_q.push_back(res);
            led_writes_seen++;
        end
        // empty segment: a single status-only result
        if (count == 0) begin
            res = '{1'b0, 6'd0, 8'd0, 8'd0, 8'd0, lssp_pkg::STAT_OK, 1'b1};
            expected_leds_q.push_back(res);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // driver
    always @(posedge aclk) begin : request_driver
        paint_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_q.pop_front();
                s_segment <= nxt.segment;
                s_red     <= nxt.red;
                s_green   <= nxt.green;
                s_blue    <= nxt.blue;
                s_power   <= nxt.power;
                s_valid   <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver backpressure, with one long hold-off each time hold_seq is bumped
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= RX_HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predicts on accepted requests, checks accepted results
    always @(posedge aclk) begin : result_monitor
        led_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                paint_predict(s_segment, s_red, s_green, s_blue, s_power);
            if (m_valid && m_ready) begin
                if (expected_leds_q.size() == 0) begin
                    $error("unexpected result: led_index %0d status %0d",
                           m_led_index, m_status);
                    fail_count++;
                end else begin
                    want = expected_leds_q.pop_front();
                    check_field("write_valid", int'(want.write_valid), int'(m_write_valid));
                    check_field("led_index", int'(want.led_index), int'(m_led_index));
                    check_field("out_red", int'(want.red), int'(m_out_red));
                    check_field("out_green", int'(want.green), int'(m_out_green));
                    check_field("out_blue", int'(want.blue), int'(m_out_blue));
                    check_field("status", int'(want.status), int'(m_status));
                    check_field("last", int'(want.last), int'(m_last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic queue_req(input logic [3:0] seg, input logic signed [8:0] r,
                             input logic signed [8:0] g, input logic signed [8:0] b,
                             input logic [1:0] pwr);
        paint_req_t req;
        req = '{seg, r, g, b, pwr};
        pending_q.push_back(req);
    endtask

    function automatic logic signed [8:0] rand_channel();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) return -9'sd1;
        if (pick < 25) return {1'b1, 8'($urandom)};
        if (pick < 55) return 9'($urandom_range(3));
        return {1'b0, 8'($urandom)};
    endfunction

    function automatic logic [3:0] rand_segment();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) return 4'd0;
        if (pick < 85) return 4'($urandom_range(NUM_SEGMENTS, 1));
        return 4'($urandom_range(15, NUM_SEGMENTS + 1));
    endfunction

    task automatic queue_random(input int n);
        repeat (n)
            queue_req(rand_segment(), rand_channel(), rand_channel(), rand_channel(),
                      2'($urandom_range(3)));
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_q.size() != 0 || s_valid || expected_leds_q.size() != 0);
    endtask

    initial begin
        for (int i = 0; i < NUM_LEDS; i++) strip_model[i] = lssp_pkg::COLOUR_BLACK;
        saved_model[0] = lssp_pkg::COLOUR_LINEN;
        for (int i = 1; i <= NUM_SEGMENTS; i++) saved_model[i] = lssp_pkg::COLOUR_SEASHELL;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 27;
        recv_idle_pct = 59;
        // long receiver hold while requests pile up behind the first one
        hold_seq++;

        queue_req(4'd0, -9'sd1, -9'sd1, -9'sd1, lssp_pkg::PWR_ON);
        queue_req(4'd1, -9'sd1, -9'sd1, -9'sd1, lssp_pkg::PWR_OFF);
        queue_req(4'd2, -9'sd1, -9'sd1, -9'sd1, lssp_pkg::PWR_HALF);
        queue_req(4'd3, -9'sd1, -9'sd1, -9'sd1, lssp_pkg::PWR_NONE);
        queue_req(4'd4, 9'sd255, 9'sd255, 9'sd255, lssp_pkg::PWR_ON);
        queue_req(4'd4, -9'sd1, -9'sd1, -9'sd1, lssp_pkg::PWR_ON);
        queue_req(4'd5, 9'sd0, 9'sd0, 9'sd0, lssp_pkg::PWR_ON);
        queue_req(4'd15, 9'sd255, 9'sd255, 9'sd255, lssp_pkg::PWR_NONE);
        queue_req(4'd1, 9'sd0, 9'sd0, 9'sd3, lssp_pkg::PWR_ON);
        queue_req(4'd1, 9'sd0, 9'sd0, 9'sd4, lssp_pkg::PWR_NONE);
        queue_req(4'd2, -9'sd256, 9'sd255, 9'sd4, lssp_pkg::PWR_HALF);
        queue_req(4'd3, 9'sd128, -9'sd1, -9'sd1, lssp_pkg::PWR_OFF);
        queue_req(4'd0, 9'sd1, 9'sd1, 9'sd1, lssp_pkg::PWR_NONE);
        queue_req(4'd0, -9'sd1, -9'sd1, -9'sd1, lssp_pkg::PWR_HALF);
        queue_req(4'd4, -9'sd256, -9'sd256, -9'sd256, lssp_pkg::PWR_NONE);
        queue_req(4'd2, 9'sd255, 9'sd0, 9'sd0, lssp_pkg::PWR_ON);
        queue_req(4'd6, 9'sd0, 9'sd0, 9'sd0, lssp_pkg::PWR_HALF);
        queue_req(4'd0, 9'sd0, 9'sd0, 9'sd0, lssp_pkg::PWR_OFF);
        queue_req(4'd3, 9'sd2, -9'sd1, 9'sd1, lssp_pkg::PWR_ON);
        queue_req(4'd1, 9'sd255, -9'sd1, -9'sd1, lssp_pkg::PWR_HALF);
        queue_random(40);
        // sender holds back until the block has drained
        wait_drained();
        queue_random(45);
        wait_drained();

        send_idle_pct = 59;
        recv_idle_pct = 27;
        queue_random(85);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(85);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_leds_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_leds_q.size());
            fail_count++;
        end

        $display("Painted %0d requests: %0d LED writes, %0d bad segments, %0d no-action",
                 requests_seen, led_writes_seen, bad_seg_seen, no_action_seen);
        $display("Ran under sender-heavy, receiver-heavy and free-running flow control");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lssp_pkg.sv
hw/rtl/lssp_ram.sv
hw/rtl/led_strip_segment_painter_top.sv
sim/led_strip_segment_painter_top_tb.sv
